[rtl/rvq_pkg.sv]
// shared constants, types and tables for the rotation vector to quaternion core
package rvq_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int IN_FRAC_BITS = 13;

    localparam int IN_W       = 16;
    localparam int OUT_W      = 16;
    localparam int SUM_W      = 32;
    localparam int SQ_W       = 48;
    localparam int ROOT_STEPS = 24;
    localparam int ANG_W      = 24;
    localparam int ATAN_LEN   = 24;
    localparam int CW         = 34;
    localparam int PW         = IN_W + CW;
    localparam int DIV_W      = 49;
    localparam int DEN_W      = ANG_W + 8;
    localparam int QB         = 16;

    localparam logic [63:0] CORDIC_GAIN30 = 64'd652032874;
    localparam logic [63:0] PI30          = 64'd3373259426;
    localparam logic [63:0] HALF_PI30     = 64'd1686629713;
    localparam logic [63:0] TWO_PI30      = 64'd6746518852;
    localparam logic [15:0] Q14_ONE       = 16'd16384;

    typedef struct packed {
        logic signed [IN_W-1:0] ax;
        logic signed [IN_W-1:0] ay;
        logic signed [IN_W-1:0] az;
        logic                   zero;
    } t_front;

    typedef struct packed {
        t_front             f;
        logic [ANG_W-1:0]   angle;
    } t_mid;

    typedef struct packed {
        t_mid   m;
        logic   neg_cos;
    } t_cord;

    typedef struct packed {
        logic [2:0]         neg;
        logic [OUT_W-1:0]   w;
        logic               zero;
    } t_tail;

    function automatic logic [31:0] atan_val(input int unsigned i);
        logic [31:0] v;
        case (i)
            0:  v = 32'd843314856;
            1:  v = 32'd497837829;
            2:  v = 32'd263043836;
            3:  v = 32'd133525158;
            4:  v = 32'd67021686;
            5:  v = 32'd33543515;
            6:  v = 32'd16775850;
            7:  v = 32'd8388437;
            8:  v = 32'd4194282;
            9:  v = 32'd2097149;
            10: v = 32'd1048575;
            11: v = 32'd524287;
            12: v = 32'd262143;
            13: v = 32'd131071;
            14: v = 32'd65535;
            15: v = 32'd32767;
            16: v = 32'd16383;
            17: v = 32'd8191;
            18: v = 32'd4095;
            19: v = 32'd2047;
            20: v = 32'd1023;
            21: v = 32'd511;
            22: v = 32'd255;
            23: v = 32'd127;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

[rtl/rotation_vector_to_quaternion_core.sv]
// top level: rotation vector to unit quaternion pipeline
// Fully pipelined: one vector is taken per clock while the output is not stalled, and
// each gives one quaternion. The pipeline holds the front register, the 24 root cells,
// RED_N range reduction cells (RED_N being 1 for 13 fraction bits), the fold register,
// one cordic cell per step, the divider set-up register, one divider cell per quotient
// bit and the output register. Every stage holds its own valid bit and only stalls when
// the stage after it is full and stalled, so bubbles close up while the output waits.
module rotation_vector_to_quaternion_core #(
    parameter int CORDIC_STEPS = rvq_pkg::CORDIC_STEPS,
    parameter int IN_FRAC_BITS = rvq_pkg::IN_FRAC_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [47:0] i_s_axis_tdata,   // rot_x, rot_y, rot_z
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [63:0] o_m_axis_tdata    // quat_x, quat_y, quat_z, quat_w
);
    localparam int SH    = 21 - IN_FRAC_BITS;
    localparam int HA_W  = rvq_pkg::ANG_W + SH;
    localparam int RED_W = (HA_W > 34) ? HA_W : 34;
    localparam int RED_N = (HA_W > 33) ? HA_W - 32 : 1;
    localparam int FW    = RED_W + 2;
    localparam int NS    = rvq_pkg::ROOT_STEPS;
    localparam int QB    = rvq_pkg::QB;
    localparam int CW    = rvq_pkg::CW;
    localparam int MID_W = $bits(rvq_pkg::t_mid);
    localparam int CRD_W = $bits(rvq_pkg::t_cord);
    localparam int TL_W  = $bits(rvq_pkg::t_tail);
    localparam int FR_W  = $bits(rvq_pkg::t_front);

    // front stage: sum of squares
    logic                        r_f_vld, w_f_adv;
    logic [rvq_pkg::SUM_W-1:0]   r_sum;
    rvq_pkg::t_front             r_front, n_front;
    logic signed [31:0]          w_sx, w_sy, w_sz;

    logic                       sq_vld  [NS+1];
    logic                       sq_rdy  [NS+1];
    logic [rvq_pkg::SQ_W-1:0]   sq_rem  [NS+1];
    logic [rvq_pkg::SQ_W-1:0]   sq_root [NS+1];
    logic [FR_W-1:0]            sq_side [NS+1];

    always_comb begin
        n_front.ax   = i_s_axis_tdata[15:0];
        n_front.ay   = i_s_axis_tdata[31:16];
        n_front.az   = i_s_axis_tdata[47:32];
        n_front.zero = 1'b0;
        w_sx = n_front.ax * n_front.ax;
        w_sy = n_front.ay * n_front.ay;
        w_sz = n_front.az * n_front.az;
    end

    assign w_f_adv         = !r_f_vld || sq_rdy[0];
    assign o_s_axis_tready = w_f_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_vld <= 1'b0;
        end else if (w_f_adv) begin
            r_f_vld <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_f_adv) begin
            r_sum   <= 32'(w_sx) + 32'(w_sy) + 32'(w_sz);
            r_front <= n_front;
        end
    end

    always_comb begin
        rvq_pkg::t_front f;
        f       = r_front;
        f.zero  = (r_sum == '0);
        sq_side[0] = f;
    end

    assign sq_vld[0]  = r_f_vld;
    assign sq_rem[0]  = {r_sum, 16'd0};
    assign sq_root[0] = '0;

    for (genvar s = 0; s < NS; s++) begin : g_sqrt
        rvq_sqrt_cell #(.STEP(s), .SIDE_W(FR_W)) u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n),
            .i_vld(sq_vld[s]), .o_rdy(sq_rdy[s]),
            .o_vld(sq_vld[s+1]), .i_rdy(sq_rdy[s+1]),
            .i_rem(sq_rem[s]), .i_root(sq_root[s]), .i_side(sq_side[s]),
            .o_rem(sq_rem[s+1]), .o_root(sq_root[s+1]), .o_side(sq_side[s+1])
        );
    end

    // range reduction of the half angle
    logic              rd_vld  [RED_N+1];
    logic              rd_rdy  [RED_N+1];
    logic [RED_W-1:0]  rd_val  [RED_N+1];
    logic [MID_W-1:0]  rd_side [RED_N+1];
    logic [rvq_pkg::ANG_W-1:0] w_angle;

    assign w_angle     = sq_root[NS][rvq_pkg::ANG_W-1:0];
    assign rd_vld[0]   = sq_vld[NS];
    assign sq_rdy[NS]  = rd_rdy[0];
    assign rd_val[0]   = RED_W'(w_angle) << SH;
    assign rd_side[0]  = {sq_side[NS], w_angle};

    for (genvar j = 0; j < RED_N; j++) begin : g_red
        rvq_red_cell #(.W(RED_W), .SHIFT(RED_N - 1 - j), .SIDE_W(MID_W)) u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n),
            .i_vld(rd_vld[j]), .o_rdy(rd_rdy[j]),
            .o_vld(rd_vld[j+1]), .i_rdy(rd_rdy[j+1]),
            .i_val(rd_val[j]), .i_side(rd_side[j]),
            .o_val(rd_val[j+1]), .o_side(rd_side[j+1])
        );
    end

    // fold into the half turn about zero
    localparam logic signed [FW-1:0] PI_F   = FW'(rvq_pkg::PI30);
    localparam logic signed [FW-1:0] HPI_F  = FW'(rvq_pkg::HALF_PI30);
    localparam logic signed [FW-1:0] TURN_F = FW'(rvq_pkg::TWO_PI30);

    logic                     r_fd_vld, w_fd_adv;
    logic signed [CW-1:0]     r_fd_z;
    logic                     r_fd_neg;
    logic [MID_W-1:0]         r_fd_side;
    logic signed [FW-1:0]     w_r0, w_r1, w_r2;
    logic                     w_neg;

    logic                 co_vld  [CORDIC_STEPS+1];
    logic                 co_rdy  [CORDIC_STEPS+1];
    logic signed [CW-1:0] co_x    [CORDIC_STEPS+1];
    logic signed [CW-1:0] co_y    [CORDIC_STEPS+1];
    logic signed [CW-1:0] co_z    [CORDIC_STEPS+1];
    logic [CRD_W-1:0]     co_side [CORDIC_STEPS+1];

    always_comb begin
        w_r0 = $signed({2'b00, rd_val[RED_N]});
        w_r1 = (w_r0 > PI_F) ? w_r0 - TURN_F : w_r0;
        w_neg = 1'b0;
        w_r2  = w_r1;
        if (w_r1 > HPI_F) begin
            w_r2  = PI_F - w_r1;
            w_neg = 1'b1;
        end else if (w_r1 < -HPI_F) begin
            w_r2  = -PI_F - w_r1;
            w_neg = 1'b1;
        end
    end

    assign w_fd_adv       = !r_fd_vld || co_rdy[0];
    assign rd_rdy[RED_N]  = w_fd_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fd_vld <= 1'b0;
        end else if (w_fd_adv) begin
            r_fd_vld <= rd_vld[RED_N];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fd_adv) begin
            r_fd_z    <= CW'(w_r2);
            r_fd_neg  <= w_neg;
            r_fd_side <= rd_side[RED_N];
        end
    end

    assign co_vld[0]  = r_fd_vld;
    assign co_x[0]    = CW'(rvq_pkg::CORDIC_GAIN30);
    assign co_y[0]    = '0;
    assign co_z[0]    = r_fd_z;
    assign co_side[0] = {r_fd_side, r_fd_neg};

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
        rvq_cordic_cell #(.STEP(i), .SIDE_W(CRD_W)) u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n),
            .i_vld(co_vld[i]), .o_rdy(co_rdy[i]),
            .o_vld(co_vld[i+1]), .i_rdy(co_rdy[i+1]),
            .i_x(co_x[i]), .i_y(co_y[i]), .i_z(co_z[i]), .i_side(co_side[i]),
            .o_x(co_x[i+1]), .o_y(co_y[i+1]), .o_z(co_z[i+1]), .o_side(co_side[i+1])
        );
    end

    // axis times sine, divider set-up and scalar part
    localparam int IN_W_L = rvq_pkg::IN_W;
    rvq_pkg::t_cord              w_cs;
    rvq_pkg::t_tail              n_tail;
    logic signed [rvq_pkg::PW-1:0] w_p [3];
    logic [rvq_pkg::PW-1:0]      w_mag [3];
    logic [rvq_pkg::DIV_W-1:0]   n_num [3];
    logic signed [IN_W_L-1:0]    w_a [3];
    logic signed [CW-1:0]        w_cos;
    logic [CW-1:0]               w_cm;
    logic [CW-16:0]              w_wr;
    logic [15:0]                 w_wsat;

    logic                        r_m_vld, w_m_adv;
    logic [rvq_pkg::DIV_W-1:0]   r_m_num [3];
    logic [rvq_pkg::DEN_W-1:0]   r_m_den;
    rvq_pkg::t_tail              r_m_tail;

    logic                        dv_vld  [QB+1];
    logic                        dv_rdy  [QB+1];
    logic [rvq_pkg::DIV_W-1:0]   dv_num  [QB+1][3];
    logic [QB-1:0]               dv_q    [QB+1][3];
    logic [rvq_pkg::DEN_W-1:0]   dv_den  [QB+1];
    logic [TL_W-1:0]             dv_side [QB+1];

    always_comb begin
        w_cs   = co_side[CORDIC_STEPS];
        w_a[0] = w_cs.m.f.ax;
        w_a[1] = w_cs.m.f.ay;
        w_a[2] = w_cs.m.f.az;
        for (int l = 0; l < 3; l++) begin
            w_p[l]   = rvq_pkg::PW'(w_a[l]) * rvq_pkg::PW'(co_y[CORDIC_STEPS]);
            w_mag[l] = w_p[l][rvq_pkg::PW-1] ? rvq_pkg::PW'(-w_p[l]) : rvq_pkg::PW'(w_p[l]);
            n_num[l] = rvq_pkg::DIV_W'(w_mag[l])
                     + rvq_pkg::DIV_W'({w_cs.m.angle, 7'd0});
            n_tail.neg[l] = w_p[l][rvq_pkg::PW-1];
        end
        w_cos  = w_cs.neg_cos ? -co_x[CORDIC_STEPS] : co_x[CORDIC_STEPS];
        w_cm   = w_cos[CW-1] ? CW'(-w_cos) : CW'(w_cos);
        w_wr   = (CW-15)'((w_cm + CW'(32768)) >> 16);
        w_wsat = (w_wr > (CW-15)'(rvq_pkg::Q14_ONE)) ? rvq_pkg::Q14_ONE : 16'(w_wr);
        n_tail.w    = w_cos[CW-1] ? 16'(-w_wsat) : w_wsat;
        n_tail.zero = w_cs.m.f.zero;
    end

    assign w_m_adv              = !r_m_vld || dv_rdy[0];
    assign co_rdy[CORDIC_STEPS] = w_m_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_vld <= 1'b0;
        end else if (w_m_adv) begin
            r_m_vld <= co_vld[CORDIC_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_m_adv) begin
            r_m_num  <= n_num;
            r_m_den  <= {w_cs.m.angle, 8'd0};
            r_m_tail <= n_tail;
        end
    end

    assign dv_vld[0]  = r_m_vld;
    assign dv_num[0]  = r_m_num;
    assign dv_q[0]    = '{default: '0};
    assign dv_den[0]  = r_m_den;
    assign dv_side[0] = r_m_tail;

    for (genvar k = 0; k < QB; k++) begin : g_div
        rvq_div_cell #(.K(QB - 1 - k), .SIDE_W(TL_W)) u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n),
            .i_vld(dv_vld[k]), .o_rdy(dv_rdy[k]),
            .o_vld(dv_vld[k+1]), .i_rdy(dv_rdy[k+1]),
            .i_num(dv_num[k]), .i_q(dv_q[k]), .i_den(dv_den[k]), .i_side(dv_side[k]),
            .o_num(dv_num[k+1]), .o_q(dv_q[k+1]), .o_den(dv_den[k+1]),
            .o_side(dv_side[k+1])
        );
    end

    // saturation and output register
    logic            r_o_vld, w_o_adv;
    logic [63:0]     r_o_data, n_o_data;
    rvq_pkg::t_tail  w_tl;
    logic [15:0]     w_qs [3];

    always_comb begin
        w_tl = dv_side[QB];
        for (int l = 0; l < 3; l++) begin
            w_qs[l] = (dv_q[QB][l] > 16'(rvq_pkg::Q14_ONE)) ? rvq_pkg::Q14_ONE
                                                            : 16'(dv_q[QB][l]);
            if (w_tl.neg[l]) begin
                w_qs[l] = -w_qs[l];
            end
        end
        if (w_tl.zero) begin
            n_o_data = {rvq_pkg::Q14_ONE, 48'd0};
        end else begin
            n_o_data = {w_tl.w, w_qs[2], w_qs[1], w_qs[0]};
        end
    end

    assign w_o_adv    = !r_o_vld || i_m_axis_tready;
    assign dv_rdy[QB] = w_o_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (w_o_adv) begin
            r_o_vld <= dv_vld[QB];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_o_adv) begin
            r_o_data <= n_o_data;
        end
    end

    assign o_m_axis_tvalid = r_o_vld;
    assign o_m_axis_tdata  = r_o_data;

    // an empty output stage means nothing upstream can be holding back
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid |-> o_s_axis_tready)
        else $error("input stalled with empty output");

    a_w_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> ($signed(o_m_axis_tdata[63:48]) <= 16'sd16384)
                         && ($signed(o_m_axis_tdata[63:48]) >= -16'sd16384))
        else $error("scalar part out of range");

    a_xyz_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> ($signed(o_m_axis_tdata[15:0]) >= -16'sd16384)
                         && ($signed(o_m_axis_tdata[15:0]) <= 16'sd16384)
                         && ($signed(o_m_axis_tdata[31:16]) >= -16'sd16384)
                         && ($signed(o_m_axis_tdata[31:16]) <= 16'sd16384)
                         && ($signed(o_m_axis_tdata[47:32]) >= -16'sd16384)
                         && ($signed(o_m_axis_tdata[47:32]) <= 16'sd16384))
        else $error("vector part out of range");
endmodule

[rtl/rvq_sqrt_cell.sv]
// one bit step of the pipelined integer square root
module rvq_sqrt_cell #(
    parameter int STEP   = 0,
    parameter int SIDE_W = 1
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_vld,
    output logic                      o_rdy,
    output logic                      o_vld,
    input  logic                      i_rdy,
    input  logic [rvq_pkg::SQ_W-1:0]  i_rem,
    input  logic [rvq_pkg::SQ_W-1:0]  i_root,
    input  logic [SIDE_W-1:0]         i_side,
    output logic [rvq_pkg::SQ_W-1:0]  o_rem,
    output logic [rvq_pkg::SQ_W-1:0]  o_root,
    output logic [SIDE_W-1:0]         o_side
);
    localparam logic [rvq_pkg::SQ_W-1:0] BIT =
        rvq_pkg::SQ_W'(1) << (rvq_pkg::SQ_W - 2 - 2 * STEP);

    logic                      r_vld;
    logic                      w_adv;
    logic [rvq_pkg::SQ_W-1:0]  r_rem, r_root, n_rem, n_root, w_trial;
    logic [SIDE_W-1:0]         r_side;

    assign w_adv = !r_vld || i_rdy;
    assign o_rdy = w_adv;
    assign o_vld = r_vld;

    always_comb begin
        w_trial = i_root + BIT;
        if (i_rem >= w_trial) begin
            n_rem  = i_rem - w_trial;
            n_root = (i_root >> 1) + BIT;
        end else begin
            n_rem  = i_rem;
            n_root = i_root >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (w_adv) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_rem  <= n_rem;
            r_root <= n_root;
            r_side <= i_side;
        end
    end

    assign o_rem  = r_rem;
    assign o_root = r_root;
    assign o_side = r_side;
endmodule

[rtl/rvq_red_cell.sv]
// one conditional subtract of a shifted full turn for range reduction
module rvq_red_cell #(
    parameter int W      = 37,
    parameter int SHIFT  = 0,
    parameter int SIDE_W = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_vld,
    output logic              o_rdy,
    output logic              o_vld,
    input  logic              i_rdy,
    input  logic [W-1:0]      i_val,
    input  logic [SIDE_W-1:0] i_side,
    output logic [W-1:0]      o_val,
    output logic [SIDE_W-1:0] o_side
);
    localparam logic [W-1:0] TURN = W'(rvq_pkg::TWO_PI30 << SHIFT);

    logic              r_vld;
    logic              w_adv;
    logic [W-1:0]      r_val, n_val;
    logic [SIDE_W-1:0] r_side;

    assign w_adv = !r_vld || i_rdy;
    assign o_rdy = w_adv;
    assign o_vld = r_vld;

    always_comb begin
        n_val = (i_val >= TURN) ? i_val - TURN : i_val;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (w_adv) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_val  <= n_val;
            r_side <= i_side;
        end
    end

    assign o_val  = r_val;
    assign o_side = r_side;
endmodule

[rtl/rvq_cordic_cell.sv]
// one rotation step of the sine and cosine cordic
module rvq_cordic_cell #(
    parameter int STEP   = 0,
    parameter int SIDE_W = 1
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_vld,
    output logic                           o_rdy,
    output logic                           o_vld,
    input  logic                           i_rdy,
    input  logic signed [rvq_pkg::CW-1:0]  i_x,
    input  logic signed [rvq_pkg::CW-1:0]  i_y,
    input  logic signed [rvq_pkg::CW-1:0]  i_z,
    input  logic [SIDE_W-1:0]              i_side,
    output logic signed [rvq_pkg::CW-1:0]  o_x,
    output logic signed [rvq_pkg::CW-1:0]  o_y,
    output logic signed [rvq_pkg::CW-1:0]  o_z,
    output logic [SIDE_W-1:0]              o_side
);
    localparam logic signed [rvq_pkg::CW-1:0] ATAN =
        rvq_pkg::CW'(rvq_pkg::atan_val(STEP));

    logic                           r_vld;
    logic                           w_adv;
    logic signed [rvq_pkg::CW-1:0]  r_x, r_y, r_z, n_x, n_y, n_z, w_dx, w_dy;
    logic [SIDE_W-1:0]              r_side;

    assign w_adv = !r_vld || i_rdy;
    assign o_rdy = w_adv;
    assign o_vld = r_vld;

    always_comb begin
        w_dx = i_y >>> STEP;
        w_dy = i_x >>> STEP;
        if (!i_z[rvq_pkg::CW-1]) begin
            n_x = i_x - w_dx;
            n_y = i_y + w_dy;
            n_z = i_z - ATAN;
        end else begin
            n_x = i_x + w_dx;
            n_y = i_y - w_dy;
            n_z = i_z + ATAN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (w_adv) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_x    <= n_x;
            r_y    <= n_y;
            r_z    <= n_z;
            r_side <= i_side;
        end
    end

    assign o_x    = r_x;
    assign o_y    = r_y;
    assign o_z    = r_z;
    assign o_side = r_side;
endmodule

[rtl/rvq_div_cell.sv]
// one quotient bit of the three-lane restoring divider
module rvq_div_cell #(
    parameter int K      = 0,
    parameter int SIDE_W = 1
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_vld,
    output logic                         o_rdy,
    output logic                         o_vld,
    input  logic                         i_rdy,
    input  logic [rvq_pkg::DIV_W-1:0]    i_num [3],
    input  logic [rvq_pkg::QB-1:0]       i_q   [3],
    input  logic [rvq_pkg::DEN_W-1:0]    i_den,
    input  logic [SIDE_W-1:0]            i_side,
    output logic [rvq_pkg::DIV_W-1:0]    o_num [3],
    output logic [rvq_pkg::QB-1:0]       o_q   [3],
    output logic [rvq_pkg::DEN_W-1:0]    o_den,
    output logic [SIDE_W-1:0]            o_side
);
    logic                         r_vld;
    logic                         w_adv;
    logic [rvq_pkg::DIV_W-1:0]    w_dk;
    logic [rvq_pkg::DIV_W-1:0]    r_num [3];
    logic [rvq_pkg::DIV_W-1:0]    n_num [3];
    logic [rvq_pkg::QB-1:0]       r_q   [3];
    logic [rvq_pkg::QB-1:0]       n_q   [3];
    logic [rvq_pkg::DEN_W-1:0]    r_den;
    logic [SIDE_W-1:0]            r_side;

    assign w_adv = !r_vld || i_rdy;
    assign o_rdy = w_adv;
    assign o_vld = r_vld;
    assign w_dk  = rvq_pkg::DIV_W'(i_den) << K;

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            n_q[l] = i_q[l];
            if (i_num[l] >= w_dk) begin
                n_num[l]  = i_num[l] - w_dk;
                n_q[l][K] = 1'b1;
            end else begin
                n_num[l] = i_num[l];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (w_adv) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_num  <= n_num;
            r_q    <= n_q;
            r_den  <= i_den;
            r_side <= i_side;
        end
    end

    assign o_num  = r_num;
    assign o_q    = r_q;
    assign o_den  = r_den;
    assign o_side = r_side;
endmodule
